// File: hw/rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants and types for the integer to decimal ascii converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // widths of the value and of the digit store
    localparam int VALUE_W    = 32;
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // ceil(2^35 / 10): floor(x * RECIP_TEN / 2^35) == floor(x / 10) for 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take a new input item
        logic step;        // peel off one digit, least significant first
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // load the next digit, most significant first
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic neg;         // value is negative
        logic quot_zero;   // this step's quotient is zero: last digit found
        logic cnt_one;     // one digit left to emit
        logic out_free;    // output register can take a character
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/itda_dp.sv
// ----------------------------------------------------------------------------
// itda_dp
// Datapath: magnitude register, divide-by-ten step, digit store and the
// output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_dp (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire signed [itda_pkg::VALUE_W-1:0] s_value,
    input  wire itda_pkg::cmd_t               cmd,
    output itda_pkg::sts_t                    sts,
    output logic [7:0]                        m_char_code,
    output logic                              m_last,
    output logic                              m_valid,
    input  wire                               m_ready
);

    localparam int W  = itda_pkg::VALUE_W;
    localparam int CW = itda_pkg::CNT_W;
    localparam int IW = itda_pkg::DIG_IDX_W;

    logic [W-1:0]   mag_reg, mag_next;
    logic           neg_reg, neg_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [3:0]     digit_reg [itda_pkg::MAX_DIGITS];
    logic [7:0]     char_reg, char_next;
    logic           last_reg, last_next;
    logic           out_valid_reg, out_valid_next;

    logic [2*W-1:0] prod;
    logic [W-1:0]   quot;
    logic [3:0]     quot_x10_lo;
    logic [3:0]     rem;
    logic [IW-1:0]  wr_idx;
    logic [IW-1:0]  rd_idx;
    logic           out_free;

    // divide by ten through the reciprocal; remainder needs only the low nibble
    assign prod        = {{W{1'b0}}, mag_reg} * {{W{1'b0}}, itda_pkg::RECIP_TEN};
    assign quot        = W'(prod[2*W-1:itda_pkg::RECIP_SHIFT]);
    assign quot_x10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign rem         = mag_reg[3:0] - quot_x10_lo;

    assign wr_idx   = cnt_reg[IW-1:0];
    assign rd_idx   = IW'(cnt_reg - CW'(1));
    assign out_free = !out_valid_reg || m_ready;

    // magnitude, sign and digit count
    always_comb begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            neg_next = s_value[W-1];
            mag_next = s_value[W-1] ? (~s_value + W'(1)) : s_value;
            cnt_next = '0;
        end else if (cmd.step) begin
            mag_next = quot;
            cnt_next = cnt_reg + CW'(1);
        end else if (cmd.emit_digit) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // output register
    always_comb begin
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (cmd.emit_sign) begin
            char_next      = itda_pkg::CHAR_MINUS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end else if (cmd.emit_digit) begin
            char_next      = itda_pkg::CHAR_ZERO + {4'b0000, digit_reg[rd_idx]};
            last_next      = (cnt_reg == CW'(1));
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (cmd.step) begin
            digit_reg[wr_idx] <= rem;
        end
    end

    assign sts.neg       = neg_reg;
    assign sts.quot_zero = (quot == '0);
    assign sts.cnt_one   = (cnt_reg == CW'(1));
    assign sts.out_free  = out_free;

    assign m_char_code = char_reg;
    assign m_last      = last_reg;
    assign m_valid     = out_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/itda_ctrl.sv
// ----------------------------------------------------------------------------
// itda_ctrl
// Controller: sequences accept, digit extraction and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire itda_pkg::sts_t sts,
    output itda_pkg::cmd_t      cmd
);

    itda_pkg::state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            itda_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = itda_pkg::ST_CONV;
                end
            end
            itda_pkg::ST_CONV: begin
                cmd.step = 1'b1;
                if (sts.quot_zero) begin
                    state_next = sts.neg ? itda_pkg::ST_SIGN : itda_pkg::ST_EMIT;
                end
            end
            itda_pkg::ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = itda_pkg::ST_EMIT;
                end
            end
            itda_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (sts.cnt_one) begin
                        state_next = itda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = itda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ascii text.
// ----------------------------------------------------------------------------
// Usage:
//   s_value carries one two's complement integer per item on a valid/ready
//   channel. The m_ channel returns its text one character per item, most
//   significant digit first, led by '-' for a negative value; m_last marks
//   the final character. Zero gives "0", the most negative value gives
//   "-2147483648".
// Timing:
//   after an item is accepted, the datapath extracts its decimal digits
//   (one 32x32 reciprocal multiply per digit, least significant
//   first), then emits one character per cycle into the output register
//   while m_ready does not stall it. The next item is accepted while the
//   last character still waits in the output register.
// Reset and stall:
//   aresetn (synchronous) returns the controller to idle and drops m_valid.
//   When m_ready is low the output register holds its character and the
//   sequencer waits; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire signed [itda_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [7:0]                         m_char_code,
    output logic                               m_last
);

    itda_pkg::cmd_t cmd;
    itda_pkg::sts_t sts;

    // sequencer
    itda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic, digit store and output register
    itda_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_char_code (m_char_code),
        .m_last      (m_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

endmodule

`default_nettype wire

// File: bench/tb_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii
// Self-checking bench for the signed integer to decimal ascii converter.
// ----------------------------------------------------------------------------
// A short table of values covers the extremes, zero, single-digit and
// ten-digit magnitudes, and powers of ten. Random values follow, mostly with
// a chosen digit count and sign. The sender offers items in bursts with
// random gaps. The receiver stalls on a changing pattern and once holds off
// for a long stretch, so the block backs up. Every character is checked in
// order against a queue of expected characters. That queue is filled from
// the typed text of a table row where the row has one, and from a
// behavioral conversion otherwise.
// ----------------------------------------------------------------------------

module tb_int_to_decimal_ascii;

    localparam int          NUM_DIRECTED = 22;
    localparam int          NUM_RANDOM   = 188;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          HOLD_AFTER   = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [31:0] DIGIT_BASE   = 32'd10;

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } rx_mode_t;

    logic                                aclk    = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [itda_pkg::VALUE_W-1:0] s_value = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [7:0]                          m_char_code;
    logic                                m_last;

    // directed values; a non-empty text is the expected output typed in
    logic [itda_pkg::VALUE_W-1:0] dir_value [NUM_DIRECTED] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10,
        32'h7FFF_FFFF, 32'h8000_0000, -32'sd2147483647,
        32'd1000000000, -32'sd1000000000,
        32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
        32'h5555_5555, 32'hAAAA_AAAA, -32'sd9, 32'd100, -32'sd100000,
        32'd42, 32'h7FFF_FFFE
    };
    string dir_text [NUM_DIRECTED] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647",
        "1000000000", "-1000000000",
        "", "", "", "",
        "", "", "-9", "", "",
        "", ""
    };

    logic [itda_pkg::VALUE_W-1:0] stim_value [$];
    string                        stim_text  [$];

    // characters still owed by the block, oldest first
    logic [7:0] text_char_q [$];
    logic       text_last_q [$];

    logic [7:0] want_char;
    logic       want_last;
    int         mismatches  = 0;
    int         cycle_count = 0;

    int_to_decimal_ascii uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // reset, held low and then released
    initial begin
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // decimal text of one value, queued most significant digit first
    task automatic queue_decimal_text(input logic [itda_pkg::VALUE_W-1:0] raw);
        logic [itda_pkg::VALUE_W-1:0] mag;
        logic [7:0]                   digits [$];
        int                           k;
        mag = raw[itda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
        do begin
            digits.push_back(itda_pkg::CHAR_ZERO + 8'(mag % DIGIT_BASE));
            mag = mag / DIGIT_BASE;
        end while (mag != 0);
        if (raw[itda_pkg::VALUE_W-1]) begin
            text_char_q.push_back(itda_pkg::CHAR_MINUS);
            text_last_q.push_back(1'b0);
        end
        for (k = digits.size() - 1; k >= 0; k--) begin
            text_char_q.push_back(digits[k]);
            text_last_q.push_back(k == 0);
        end
    endtask

    // text typed into the table, queued as is
    task automatic queue_typed_text(input string txt);
        int k;
        for (k = 0; k < txt.len(); k++) begin
            text_char_q.push_back(txt[k]);
            text_last_q.push_back(k == txt.len() - 1);
        end
    endtask

    // random value: mostly a chosen digit count and sign, some raw words
    function automatic logic [itda_pkg::VALUE_W-1:0] random_value();
        int                n_digits;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   mag;
        int                k;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom();
        end
        n_digits = $urandom_range(1, 10);
        hi = 1;
        for (k = 0; k < n_digits; k++) begin
            hi = hi * 10;
        end
        lo = (n_digits == 1) ? 0 : hi / 10;
        hi = hi - 1;
        if (hi > 64'd2147483647) begin
            hi = 64'd2147483647;
        end
        mag = lo + ({$urandom(), $urandom()} % (hi - lo + 1));
        if ($urandom_range(0, 1) == 1) begin
            return itda_pkg::VALUE_W'(-mag);
        end
        return itda_pkg::VALUE_W'(mag);
    endfunction

    // sender: bursts of items with random gaps, then drain and report
    initial begin : sender
        int burst_left;
        int idx;
        for (idx = 0; idx < NUM_DIRECTED; idx++) begin
            stim_value.push_back(dir_value[idx]);
            stim_text.push_back(dir_text[idx]);
        end
        for (idx = 0; idx < NUM_RANDOM; idx++) begin
            stim_value.push_back(random_value());
            stim_text.push_back("");
        end

        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);

        burst_left = 0;
        for (idx = 0; idx < stim_value.size(); idx++) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            s_valid <= 1'b1;
            s_value <= stim_value[idx];
            do @(posedge aclk); while (s_ready !== 1'b1);
            if (stim_text[idx].len() != 0) begin
                queue_typed_text(stim_text[idx]);
            end else begin
                queue_decimal_text(stim_value[idx]);
            end
        end
        s_valid <= 1'b0;

        // wait for every owed character, then watch for strays
        while (text_char_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // receiver: stall pattern changes at random intervals, one long hold
    initial begin : receiver
        int       accepted;
        int       hold_left;
        int       phase_left;
        int       cadence;
        bit       hold_done;
        rx_mode_t mode;
        accepted   = 0;
        hold_left  = 0;
        phase_left = 0;
        cadence    = 0;
        hold_done  = 1'b0;
        mode       = RX_FREE;
        forever begin
            @(posedge aclk);
            if (aresetn && s_valid && s_ready) begin
                accepted++;
            end
            if (!hold_done && accepted >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            cadence++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = rx_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(20, 80);
                end
                phase_left--;
                case (mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= $urandom_range(0, 1);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (cadence % 3 != 0);
                endcase
            end
        end
    end

    // compare each accepted character with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (text_char_q.size() == 0) begin
                $error("char_code: expected nothing, actual %0d (last %0b)",
                       m_char_code, m_last);
                mismatches++;
            end else begin
                want_char = text_char_q.pop_front();
                want_last = text_last_q.pop_front();
                if (m_char_code !== want_char) begin
                    $error("char_code: expected %0d, actual %0d", want_char, m_char_code);
                    mismatches++;
                end
                if (m_last !== want_last) begin
                    $error("last: expected %0b, actual %0b", want_last, m_last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/itda_pkg.sv
hw/rtl/itda_dp.sv
hw/rtl/itda_ctrl.sv
hw/rtl/int_to_decimal_ascii.sv
bench/tb_int_to_decimal_ascii.sv
